// File: hdl/csrtc_pkg.sv
// Shared types and constants of the CSR triangle counter.
// Used by the RAM-backed datapath, the sequencer and the top level.
package csrtc_pkg;

	localparam int DEF_MAX_VERTICES = 4096;
	localparam int DEF_MAX_EDGES    = 65536;
	localparam int NB_W             = 12;
	localparam int MARK_DEPTH       = 4096;
	localparam int COUNT_W          = 32;
	localparam int VC_W             = 13;
	localparam int CFG_IDX_W        = 8;
	localparam int CFG_DATA_W       = 13;

	localparam logic [1:0] OP_LOAD_VTX = 2'd0;
	localparam logic [1:0] OP_LOAD_EDGE = 2'd1;
	localparam logic [1:0] OP_RUN      = 2'd2;
	localparam logic [1:0] OP_READ     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTR_MODE    = 8'd1;

	localparam logic KIND_TOTAL = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	typedef struct packed {
		logic ld_vtx;
		logic ld_nb;
		logic run_init;
		logic rd_issue;
		logic clr_step;
		logic u_rd;
		logic u_span;
		logic u_inc;
		logic nb_rd_e;
		logic nb_rd_f;
		logic e_rewind;
		logic e_inc;
		logic mark_set;
		logic mark_clr;
		logic v_rd;
		logic v_span;
		logic f_inc;
		logic mark_rd;
		logic tot_inc;
		logic vc_rd;
		logic vc_inc;
		logic out_total;
		logic out_read;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic u_done;
		logic e_done;
		logic f_done;
		logic nb_gt_u;
		logic nb_gt_v;
		logic mark_hit;
		logic attr;
		logic out_free;
	} sts_t;

endpackage

// File: hdl/csrtc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csrtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/csrtc_datapath.sv
// Datapath: graph stores, member marks, per-vertex counts, scan counters,
// total and output register. Depends on csrtc_pkg and csrtc_ram.
module csrtc_datapath import csrtc_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [15:0]           slot,
	input  logic [15:0]           edge_start,
	input  logic [16:0]           degree,
	input  logic [NB_W-1:0]       neighbor,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic                  m_tuser,
	output logic [COUNT_W-1:0]    m_tdata
);

	localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int EW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int VC    = $clog2(MAX_VERTICES + 1);
	localparam int EC    = $clog2(MAX_EDGES + 1);
	localparam int CLR_N = (MAX_VERTICES > MARK_DEPTH) ? MAX_VERTICES : MARK_DEPTH;
	localparam int CW    = $clog2(CLR_N);
	localparam int MW    = $clog2(MARK_DEPTH);
	localparam logic [31:0] MV32 = 32'(MAX_VERTICES);
	localparam logic [31:0] ME32 = 32'(MAX_EDGES);

	logic [VC_W-1:0]    vertex_count_q;
	logic               attr_q;
	logic               ran_q;
	logic               rd_ok_q;
	logic [CW-1:0]      clr_q;
	logic [VC-1:0]      u_q;
	logic [EC-1:0]      lo_q, hi_q, e_q, fhi_q, f_q;
	logic [NB_W-1:0]    v_q, w_q, top_q;
	logic               top_ok_q;
	logic [COUNT_W-1:0] total_q;
	logic               out_valid_q, out_kind_q;
	logic [COUNT_W-1:0] out_data_q;

	logic [32:0]        vtx_rd;
	logic [NB_W-1:0]    nb_rd;
	logic [0:0]         mark_rd;
	logic [COUNT_W-1:0] vc_rdata;

	logic [31:0] slot32, nv32, sp_s, sp_e, lo32, hi32, w32, nb32, clr32;
	logic        new_max, out_free;

	// slot and neighbor values widened once, then cut to each store's address
	always_comb begin
		slot32 = 32'(slot);
		nb32   = 32'(nb_rd);
		w32    = 32'(w_q);
		clr32  = 32'(clr_q);
		nv32   = (32'(vertex_count_q) > MV32) ? MV32 : 32'(vertex_count_q);
		sp_s   = 32'(vtx_rd[15:0]);
		sp_e   = sp_s + 32'(vtx_rd[32:16]);
		lo32   = (sp_s < ME32) ? sp_s : 32'd0;
		hi32   = (sp_s < ME32) ? ((sp_e > ME32) ? ME32 : sp_e) : 32'd0;
		new_max = !top_ok_q || (nb_rd > top_q);
		out_free = !out_valid_q || m_tready;
	end

	always_comb begin
		sts.clr_last = (clr32 == 32'(CLR_N - 1));
		sts.u_done   = (32'(u_q) >= nv32);
		sts.e_done   = (e_q >= hi_q);
		sts.f_done   = (f_q >= fhi_q);
		sts.nb_gt_u  = (nb32 > 32'(u_q));
		sts.nb_gt_v  = (nb_rd > v_q);
		sts.mark_hit = mark_rd[0];
		sts.attr     = attr_q;
		sts.out_free = out_free;
	end

	csrtc_ram #(.WIDTH(33), .DEPTH(MAX_VERTICES)) u_vtx_ram (
		.clk   (clk),
		.we    (cmd.ld_vtx && (slot32 < MV32)),
		.waddr (slot32[VW-1:0]),
		.wdata ({degree, edge_start}),
		.re    (cmd.u_rd || cmd.v_rd),
		.raddr (cmd.v_rd ? nb32[VW-1:0] : u_q[VW-1:0]),
		.rdata (vtx_rd)
	);

	csrtc_ram #(.WIDTH(NB_W), .DEPTH(MAX_EDGES)) u_nb_ram (
		.clk   (clk),
		.we    (cmd.ld_nb && (slot32 < ME32)),
		.waddr (slot32[EW-1:0]),
		.wdata (neighbor),
		.re    (cmd.nb_rd_e || cmd.nb_rd_f),
		.raddr (cmd.nb_rd_f ? f_q[EW-1:0] : e_q[EW-1:0]),
		.rdata (nb_rd)
	);

	csrtc_ram #(.WIDTH(1), .DEPTH(MARK_DEPTH)) u_mark_ram (
		.clk   (clk),
		.we    ((cmd.clr_step && (clr32 < 32'(MARK_DEPTH))) ||
		        (cmd.mark_set && new_max) || cmd.mark_clr),
		.waddr (cmd.clr_step ? clr32[MW-1:0] : nb_rd),
		.wdata (cmd.mark_set),
		.re    (cmd.mark_rd),
		.raddr (nb_rd),
		.rdata (mark_rd)
	);

	csrtc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_VERTICES)) u_vc_ram (
		.clk   (clk),
		.we    ((cmd.clr_step && (clr32 < MV32)) || cmd.vc_inc),
		.waddr (cmd.clr_step ? clr32[VW-1:0] : w32[VW-1:0]),
		.wdata (cmd.clr_step ? '0 : ((&vc_rdata) ? vc_rdata : vc_rdata + 1'b1)),
		.re    (cmd.rd_issue || cmd.vc_rd),
		.raddr (cmd.rd_issue ? slot32[VW-1:0] : w32[VW-1:0]),
		.rdata (vc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
			attr_q         <= 1'b0;
			ran_q          <= 1'b0;
			out_valid_q    <= 1'b0;
			top_ok_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == REG_VERTEX_COUNT) begin
				vertex_count_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_ATTR_MODE) begin
				attr_q <= cfg_data[0];
			end
			if (cmd.run_init) begin
				ran_q <= 1'b1;
			end
			if (cmd.u_span) begin
				top_ok_q <= 1'b0;
			end else if (cmd.mark_set && new_max) begin
				top_ok_q <= 1'b1;
			end
			if (cmd.out_total || cmd.out_read) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_init) begin
			clr_q   <= '0;
			u_q     <= '0;
			total_q <= '0;
		end
		if (cmd.clr_step && !sts.clr_last) begin
			clr_q <= clr_q + 1'b1;
		end
		if (cmd.u_inc) begin
			u_q <= u_q + 1'b1;
		end
		if (cmd.rd_issue) begin
			rd_ok_q <= ran_q && (slot32 < MV32);
		end
		if (cmd.u_span) begin
			lo_q <= lo32[EC-1:0];
			hi_q <= hi32[EC-1:0];
			e_q  <= lo32[EC-1:0];
		end
		if (cmd.e_rewind) begin
			e_q <= lo_q;
		end
		if (cmd.e_inc || cmd.mark_set || cmd.mark_clr) begin
			e_q <= e_q + 1'b1;
		end
		if (cmd.mark_set && new_max) begin
			top_q <= nb_rd;
		end
		if (cmd.v_rd) begin
			v_q <= nb_rd;
		end
		if (cmd.v_span) begin
			fhi_q <= hi32[EC-1:0];
			f_q   <= lo32[EC-1:0];
		end
		if (cmd.f_inc) begin
			f_q <= f_q + 1'b1;
		end
		if (cmd.mark_rd) begin
			w_q <= nb_rd;
		end
		if (cmd.tot_inc && !(&total_q)) begin
			total_q <= total_q + 1'b1;
		end
		if (cmd.out_total) begin
			out_kind_q <= KIND_TOTAL;
			out_data_q <= total_q;
		end else if (cmd.out_read) begin
			out_kind_q <= KIND_VERTEX;
			out_data_q <= rd_ok_q ? vc_rdata : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = out_data_q;

endmodule

// File: hdl/csrtc_ctrl.sv
// Sequencer for loads, reads and the triangle-count run.
// Depends on csrtc_pkg; drives the datapath through cmd_t, watches sts_t.
module csrtc_ctrl import csrtc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] opcode,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [16:0] {
		ST_IDLE    = 17'h00001,
		ST_CLR     = 17'h00002,
		ST_U_CHK   = 17'h00004,
		ST_U_SPAN  = 17'h00008,
		ST_MARK_RD = 17'h00010,
		ST_MARK_WR = 17'h00020,
		ST_V_RD    = 17'h00040,
		ST_V_CHK   = 17'h00080,
		ST_V_SPAN  = 17'h00100,
		ST_W_RD    = 17'h00200,
		ST_W_CHK   = 17'h00400,
		ST_W_HIT   = 17'h00800,
		ST_W_INC   = 17'h01000,
		ST_CM_RD   = 17'h02000,
		ST_CM_WR   = 17'h04000,
		ST_FIN     = 17'h08000,
		ST_RD_WAIT = 17'h10000
	} state_t;

	state_t state_q, state_d;
	logic   take;

	assign s_tready = (state_q == ST_IDLE);
	assign take     = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (opcode)
						OP_LOAD_VTX:  cmd.ld_vtx = 1'b1;
						OP_LOAD_EDGE: cmd.ld_nb = 1'b1;
						OP_RUN: begin
							cmd.run_init = 1'b1;
							state_d = ST_CLR;
						end
						OP_READ: begin
							cmd.rd_issue = 1'b1;
							state_d = ST_RD_WAIT;
						end
						default: ;
					endcase
				end
			end
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_U_CHK;
			end
			ST_U_CHK: begin
				if (sts.u_done) begin
					state_d = ST_FIN;
				end else begin
					cmd.u_rd = 1'b1;
					state_d = ST_U_SPAN;
				end
			end
			ST_U_SPAN: begin
				cmd.u_span = 1'b1;
				state_d = ST_MARK_RD;
			end
			// mark running maxima of N(u)
			ST_MARK_RD: begin
				if (sts.e_done) begin
					cmd.e_rewind = 1'b1;
					state_d = ST_V_RD;
				end else begin
					cmd.nb_rd_e = 1'b1;
					state_d = ST_MARK_WR;
				end
			end
			ST_MARK_WR: begin
				cmd.mark_set = 1'b1;
				state_d = ST_MARK_RD;
			end
			ST_V_RD: begin
				if (sts.e_done) begin
					cmd.e_rewind = 1'b1;
					state_d = ST_CM_RD;
				end else begin
					cmd.nb_rd_e = 1'b1;
					state_d = ST_V_CHK;
				end
			end
			ST_V_CHK: begin
				if (sts.nb_gt_u) begin
					cmd.e_rewind = 1'b1;
					state_d = ST_CM_RD;
				end else begin
					cmd.v_rd = 1'b1;
					state_d = ST_V_SPAN;
				end
			end
			ST_V_SPAN: begin
				cmd.v_span = 1'b1;
				state_d = ST_W_RD;
			end
			ST_W_RD: begin
				if (sts.f_done) begin
					cmd.e_inc = 1'b1;
					state_d = ST_V_RD;
				end else begin
					cmd.nb_rd_f = 1'b1;
					state_d = ST_W_CHK;
				end
			end
			ST_W_CHK: begin
				if (sts.nb_gt_v) begin
					cmd.e_inc = 1'b1;
					state_d = ST_V_RD;
				end else begin
					cmd.mark_rd = 1'b1;
					state_d = ST_W_HIT;
				end
			end
			ST_W_HIT: begin
				if (sts.mark_hit && sts.attr) begin
					cmd.tot_inc = 1'b1;
					cmd.vc_rd = 1'b1;
					state_d = ST_W_INC;
				end else begin
					cmd.tot_inc = sts.mark_hit;
					cmd.f_inc = 1'b1;
					state_d = ST_W_RD;
				end
			end
			ST_W_INC: begin
				cmd.vc_inc = 1'b1;
				cmd.f_inc = 1'b1;
				state_d = ST_W_RD;
			end
			// drop the marks of N(u) before the next vertex
			ST_CM_RD: begin
				if (sts.e_done) begin
					cmd.u_inc = 1'b1;
					state_d = ST_U_CHK;
				end else begin
					cmd.nb_rd_e = 1'b1;
					state_d = ST_CM_WR;
				end
			end
			ST_CM_WR: begin
				cmd.mark_clr = 1'b1;
				state_d = ST_CM_RD;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_total = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RD_WAIT: begin
				if (sts.out_free) begin
					cmd.out_read = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/csr_triangle_counter.sv
// Top level of the CSR triangle counter: sequencer plus datapath.
// Depends on csrtc_pkg, csrtc_ctrl, csrtc_datapath (and csrtc_ram below it).
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   s_tuser: opcode[1:0]; s_tdata: slot, edge_start,
//                                   degree, neighbor (from bit 0)
// m_       out  m_tvalid/m_tready   m_tuser: result_kind; m_tdata: count_value
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// Loads stream back to back; a read issues the per-vertex count lookup, then waits
// for a free output register. A run first sweeps max(MAX_VERTICES, 4096) addresses
// clearing the per-vertex counts and member marks, then per u reads N(u) to set
// marks, tries each candidate v (read, check, span) and its candidates w (read,
// check, hit test), and reads N(u) again to drop the marks, via one edge RAM port.
// Input is held off while a run or read is in flight or its result is stalled.
// Reset clears control only; stores are undefined until loaded.
module csr_triangle_counter import csrtc_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            s_tuser,   // opcode
	input  logic [63:0]           s_tdata,   // slot, edge_start, degree, neighbor, zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [0:0]            m_tuser,   // result_kind
	output logic [COUNT_W-1:0]    m_tdata,   // count_value
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	csrtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	csrtc_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.slot       (s_tdata[15:0]),
		.edge_start (s_tdata[31:16]),
		.degree     (s_tdata[48:32]),
		.neighbor   (s_tdata[60:49]),
		.cmd        (cmd),
		.sts        (sts),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tuser    (m_tuser[0]),
		.m_tdata    (m_tdata)
	);

	a_one_nb_port: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.nb_rd_e, cmd.nb_rd_f}))
		else $error("edge RAM read from two sources");

	a_hit_after_mark: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tot_inc |-> $past(cmd.mark_rd))
		else $error("total advanced without a mark lookup");

	a_inc_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.vc_inc |-> $past(cmd.vc_rd))
		else $error("vertex count written without a read");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_total || cmd.out_read) |-> !(s_tvalid && s_tready))
		else $error("item accepted while a result is issued");

endmodule
